/* hdl/wsd_pkg.sv */
// Package: transaction types and codes shared by the frame deframer modules.
package wsd_pkg;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_MALFORMED = 2'd1;
  localparam logic [1:0] ERR_TOO_LARGE = 2'd2;

  localparam logic [3:0] OPC_CONT   = 4'h0;
  localparam logic [3:0] OPC_TEXT   = 4'h1;
  localparam logic [3:0] OPC_BINARY = 4'h2;
  localparam logic [3:0] OPC_CLOSE  = 4'h8;
  localparam logic [3:0] OPC_PING   = 4'h9;
  localparam logic [3:0] OPC_PONG   = 4'hA;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [62:0] MAX_PAYLOAD_RESET = 63'd1048576;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } wsd_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  frame_opcode;
    logic        fin;
    logic [62:0] payload_length;
    logic [7:0]  data;
    logic        last;
    logic [1:0]  error_code;
  } wsd_out_t;

endpackage

/* hdl/websocket_frame_deframer.sv */
// Top level: WebSocket frame deframer, byte stream in, headers and unmasked payload out.
// A byte in the input register passes through the combinational parse step into the output
//   register; bytes that give no result only update the frame state.
// Throughput: one byte per cycle unless out_ready holds the output register full.
// Reset (rst, synchronous): clears frame state, awaits a first header byte,
//   and sets max_payload to 1048576; no clearing pass.
module websocket_frame_deframer
  import wsd_pkg::*;
#(
  parameter int LENGTH_BITS = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  wsd_in_t     in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output wsd_out_t    out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [62:0] cfg_data
);

  logic     advance;
  logic     full;
  logic     fire;
  wsd_in_t  item;
  logic     res_valid;
  wsd_out_t res;

  assign cfg_ready = 1'b1;
  assign fire      = full && advance;

  wsd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .advance  (advance),
    .full     (full),
    .item     (item)
  );

  wsd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  wsd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

/* hdl/wsd_in_stage.sv */
// Input register stage of the frame deframer.
module wsd_in_stage
  import wsd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  wsd_in_t in_item,
  input  logic    advance,
  output logic    full,
  output wsd_in_t item
);

  assign in_ready = !full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && in_ready) begin
      full <= 1'b1;
    end else if (advance) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

/* hdl/wsd_parser.sv */
// Frame header parser, length checks, key capture and payload unmasking.
module wsd_parser
  import wsd_pkg::*;
#(
  parameter int LENGTH_BITS = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [62:0] cfg_data,
  input  logic        fire,
  input  wsd_in_t     item,
  output logic        res_valid,
  output wsd_out_t    res
);

  typedef enum logic [6:0] {
    PH_HDR0  = 7'b0000001,
    PH_HDR1  = 7'b0000010,
    PH_EXT16 = 7'b0000100,
    PH_EXT64 = 7'b0001000,
    PH_KEY   = 7'b0010000,
    PH_DATA  = 7'b0100000,
    PH_HALT  = 7'b1000000
  } phase_t;

  logic [62:0]            max_payload;
  phase_t                 phase, phase_next;
  logic [7:0]             first_header_byte, first_header_byte_next;
  logic [63:0]            length_accumulator, length_accumulator_next;
  logic [2:0]             extended_byte_count, extended_byte_count_next;
  logic [31:0]            mask_key, mask_key_next;
  logic [1:0]             mask_byte_count, mask_byte_count_next;
  logic [LENGTH_BITS-1:0] bytes_remaining, bytes_remaining_next;
  logic [1:0]             mask_lane, mask_lane_next;

  logic [7:0]  b;
  logic [3:0]  opc;
  logic        known_op;
  logic [63:0] acc_shift;
  logic [63:0] len_cand;
  logic        over_max, ctrl_big, beyond;

  assign b         = item.data_byte;
  assign opc       = first_header_byte[3:0];
  assign known_op  = (opc == OPC_CONT) || (opc == OPC_TEXT) || (opc == OPC_BINARY) ||
                     (opc == OPC_CLOSE) || (opc == OPC_PING) || (opc == OPC_PONG);
  assign acc_shift = {length_accumulator[55:0], b};
  assign len_cand  = (phase == PH_HDR1) ? {57'd0, b[6:0]} : acc_shift;
  assign over_max  = len_cand > {1'b0, max_payload};
  assign ctrl_big  = opc[3] && (len_cand > 64'd125);
  assign beyond    = (len_cand >> LENGTH_BITS) != 64'd0;

  always_comb begin
    phase_next               = phase;
    first_header_byte_next   = first_header_byte;
    length_accumulator_next  = length_accumulator;
    extended_byte_count_next = extended_byte_count;
    mask_key_next            = mask_key;
    mask_byte_count_next     = mask_byte_count;
    bytes_remaining_next     = bytes_remaining;
    mask_lane_next           = mask_lane;
    res_valid                = 1'b0;
    res                      = '0;
    res.frame_opcode         = first_header_byte[3:0];
    res.fin                  = first_header_byte[7];
    if (fire) begin
      if (item.op == OP_RESTART) begin
        phase_next               = PH_HDR0;
        first_header_byte_next   = '0;
        length_accumulator_next  = '0;
        extended_byte_count_next = '0;
        mask_key_next            = '0;
        mask_byte_count_next     = '0;
        bytes_remaining_next     = '0;
        mask_lane_next           = '0;
      end else begin
        case (phase)
          PH_HDR0: begin
            first_header_byte_next = b;
            phase_next             = PH_HDR1;
          end
          PH_HDR1: begin
            if (first_header_byte[6:4] != 3'd0 || !known_op || !b[7] ||
                (opc[3] && !first_header_byte[7])) begin
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_MALFORMED;
            end else begin
              length_accumulator_next  = '0;
              extended_byte_count_next = '0;
              if (b[6:0] == LEN7_EXT16) begin
                phase_next = PH_EXT16;
              end else if (b[6:0] == LEN7_EXT64) begin
                phase_next = PH_EXT64;
              end else if (over_max || ctrl_big || beyond) begin
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = (over_max || !ctrl_big) ? ERR_TOO_LARGE : ERR_MALFORMED;
              end else begin
                length_accumulator_next = len_cand;
                mask_key_next           = '0;
                mask_byte_count_next    = '0;
                phase_next              = PH_KEY;
              end
            end
          end
          PH_EXT16, PH_EXT64: begin
            length_accumulator_next = acc_shift;
            if ((phase == PH_EXT16 && extended_byte_count < 3'd1) ||
                (phase == PH_EXT64 && extended_byte_count < 3'd7)) begin
              extended_byte_count_next = extended_byte_count + 3'd1;
            end else if ((phase == PH_EXT16 && acc_shift < 64'd126) ||
                         (phase == PH_EXT64 &&
                          (acc_shift[63] || acc_shift < 64'd65536))) begin
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_MALFORMED;
            end else if (over_max || ctrl_big || beyond) begin
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = (over_max || !ctrl_big) ? ERR_TOO_LARGE : ERR_MALFORMED;
            end else begin
              mask_key_next        = '0;
              mask_byte_count_next = '0;
              phase_next           = PH_KEY;
            end
          end
          PH_KEY: begin
            mask_key_next[{mask_byte_count, 3'b000} +: 8] =
              mask_key[{mask_byte_count, 3'b000} +: 8] | b;
            if (mask_byte_count < 2'd3) begin
              mask_byte_count_next = mask_byte_count + 2'd1;
            end else begin
              mask_byte_count_next = '0;
              mask_lane_next       = '0;
              bytes_remaining_next = length_accumulator[LENGTH_BITS-1:0];
              res_valid            = 1'b1;
              res.kind             = KIND_HEADER;
              res.payload_length   = length_accumulator[62:0];
              res.last             = (length_accumulator[LENGTH_BITS-1:0] == '0);
              phase_next           = res.last ? PH_HDR0 : PH_DATA;
            end
          end
          PH_DATA: begin
            mask_lane_next       = mask_lane + 2'd1;
            bytes_remaining_next = bytes_remaining - LENGTH_BITS'(1);
            res_valid            = 1'b1;
            res.kind             = KIND_DATA;
            res.data             = b ^ mask_key[{mask_lane, 3'b000} +: 8];
            res.last             = (bytes_remaining == LENGTH_BITS'(1));
            if (res.last) begin
              phase_next = PH_HDR0;
            end
          end
          PH_HALT: begin
          end
          default: begin
          end
        endcase
        if (res_valid && res.kind == KIND_ERROR) begin
          phase_next = PH_HALT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload         <= MAX_PAYLOAD_RESET;
      phase               <= PH_HDR0;
      first_header_byte   <= '0;
      length_accumulator  <= '0;
      extended_byte_count <= '0;
      mask_key            <= '0;
      mask_byte_count     <= '0;
      bytes_remaining     <= '0;
      mask_lane           <= '0;
    end else begin
      if (cfg_valid) begin
        max_payload <= cfg_data;
      end
      phase               <= phase_next;
      first_header_byte   <= first_header_byte_next;
      length_accumulator  <= length_accumulator_next;
      extended_byte_count <= extended_byte_count_next;
      mask_key            <= mask_key_next;
      mask_byte_count     <= mask_byte_count_next;
      bytes_remaining     <= bytes_remaining_next;
      mask_lane           <= mask_lane_next;
    end
  end

`ifndef SYNTHESIS
  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == KIND_ERROR) |=> (phase == PH_HALT))
    else $error("error report did not halt the parser");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && item.op == OP_RESTART) |=> (phase == PH_HDR0 && bytes_remaining == '0))
    else $error("restart did not clear frame state");

  a_data_nonempty: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (bytes_remaining != '0))
    else $error("payload phase with no bytes remaining");
`endif

endmodule

/* hdl/wsd_out_stage.sv */
// Output result register of the frame deframer.
module wsd_out_stage
  import wsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     fire,
  input  logic     res_valid,
  input  wsd_out_t res,
  output logic     advance,
  output logic     out_valid,
  input  logic     out_ready,
  output wsd_out_t out_item
);

  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= res;
    end
  end

`ifndef SYNTHESIS
  a_error_code_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_item.kind == KIND_ERROR) == (out_item.error_code != ERR_NONE)))
    else $error("error code does not match result kind");
`endif

endmodule
